[design/dsrc_pkg.sv]
// Package for the dual stepper ramp controller: widths, command and register codes.
// No dependencies.
`timescale 1ns / 1ps
package dsrc_pkg;
    localparam int PW = 24;
    localparam int CW = 32;
    localparam logic [PW-1:0] PMASK = {PW{1'b1}};

    localparam logic [2:0] ACT_RAMP   = 3'd0;
    localparam logic [2:0] ACT_STEP   = 3'd1;
    localparam logic [2:0] ACT_RPM    = 3'd2;
    localparam logic [2:0] ACT_PERIOD = 3'd3;
    localparam logic [2:0] ACT_ENABLE = 3'd4;
    localparam logic [2:0] ACT_POWER  = 3'd5;
    localparam logic [2:0] ACT_DIR    = 3'd6;
    localparam logic [2:0] ACT_RUN    = 3'd7;

    localparam logic [2:0] REG_RATE  = 3'd0;
    localparam logic [2:0] REG_DRPM  = 3'd1;
    localparam logic [2:0] REG_CONV  = 3'd2;
    localparam logic [2:0] REG_RMIN  = 3'd3;
    localparam logic [2:0] REG_RMAX  = 3'd4;
    localparam logic [2:0] REG_PMIN  = 3'd5;
    localparam logic [2:0] REG_PMAX  = 3'd6;

    // divider request/response
    typedef struct packed {
        logic          start;
        logic [PW-1:0] num;
        logic [PW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] quo;
    } div_rsp_t;
endpackage

[design/dual_stepper_ramp_controller_top.sv]
// Top level: APB registers, command sequencer, motor state, shared serial divider.
// Depends on dsrc_pkg and dsrc_div.
// The sequencer runs its divisions one after another on the shared divider, and a zero
// divisor skips the shift loop; a ramp tick uses three of them (two when already at goal).
// Commands are taken one at a time; s_tready is high while the sequencer idles; a result
// waiting in the output register holds the next result in S_PUT and, with it, the sequencer.
// Reset: asynchronous, active low; registers and motor state to their defaults.
`timescale 1ns / 1ps
module dual_stepper_ramp_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // action[2:0], motor[3], value[27:4], flag[28]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // step_a,step_b,dir_a,dir_b,pwr_a,pwr_b,run_a,run_b,
                                   // counted[8], period_now[32:9], rpm_now[56:33]
);
    import dsrc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_D1   = 3'd1;  // first division running
    localparam logic [2:0] S_D2   = 3'd2;  // second ramp division
    localparam logic [2:0] S_FIN  = 3'd3;  // apply
    localparam logic [2:0] S_D3   = 3'd4;  // reported rpm division
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_PUT  = 3'd6;  // hand result to output register

    // configuration registers
    logic [6:0]    rate_reg;
    logic [9:0]    drpm_reg, rmin_reg, rmax_reg;
    logic [PW-1:0] conv_reg, pmin_reg, pmax_reg;
    logic          wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 7'd10;
            drpm_reg <= 10'd60;
            conv_reg <= 24'd18750;
            rmin_reg <= 10'd1;
            rmax_reg <= 10'd300;
            pmin_reg <= 24'd60;
            pmax_reg <= 24'd18750;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                REG_RATE: rate_reg <= pwdata[6:0];
                REG_DRPM: drpm_reg <= pwdata[9:0];
                REG_CONV: conv_reg <= pwdata[23:0];
                REG_RMIN: rmin_reg <= pwdata[9:0];
                REG_RMAX: rmax_reg <= pwdata[9:0];
                REG_PMIN: pmin_reg <= pwdata[23:0];
                REG_PMAX: pmax_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_RATE: prdata = {25'd0, rate_reg};
            REG_DRPM: prdata = {22'd0, drpm_reg};
            REG_CONV: prdata = {8'd0, conv_reg};
            REG_RMIN: prdata = {22'd0, rmin_reg};
            REG_RMAX: prdata = {22'd0, rmax_reg};
            REG_PMIN: prdata = {8'd0, pmin_reg};
            REG_PMAX: prdata = {8'd0, pmax_reg};
            default:  prdata = '0;
        endcase
    end

    // motor state
    logic [PW-1:0] half_reg [2];
    logic [PW-1:0] goal_reg [2];
    logic [1:0]    run_reg, pwr_reg, dir_reg, lvl_reg;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] egoal_reg;
    logic          cmode_reg;

    logic [2:0]    state_reg;
    logic [2:0]    act_reg;
    logic          m_reg;
    logic [PW-1:0] val_reg;
    logic          flag_reg;
    logic [63:0]   out_reg;
    logic          ovalid_reg;
    logic          load_out;

    div_req_t dreq;
    div_rsp_t drsp;
    dsrc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [PW-1:0] cur, goal;
    assign cur  = half_reg[m_reg];
    assign goal = goal_reg[m_reg];

    // ramp rpm candidate from first quotient
    logic [PW:0] up_rpm;
    logic [PW:0] dn_rpm;
    logic        dn_neg;
    assign up_rpm = {1'b0, drsp.quo} + (PW+1)'(rate_reg);
    assign dn_neg = drsp.quo < PW'(rate_reg);
    assign dn_rpm = {1'b0, drsp.quo} - (PW+1)'(rate_reg);

    // new period bounding
    logic [PW-1:0] np;
    always_comb
    begin
        np = drsp.quo;
        if (cur > goal)
        begin
            if (np >= cur) np = cur - 1'b1;
            if (np < goal) np = goal;
        end
        else
        begin
            if (np <= cur) np = cur + 1'b1;
            if (np > goal) np = goal;
        end
    end

    logic [PW-1:0] clamped;
    always_comb
    begin
        clamped = drsp.quo;
        if (drsp.quo < pmin_reg) clamped = pmin_reg;
        else if (drsp.quo > pmax_reg) clamped = pmax_reg;
    end

    logic [PW-1:0] vclamp;
    always_comb
    begin
        vclamp = val_reg;
        if (val_reg < pmin_reg) vclamp = pmin_reg;
        else if (val_reg > pmax_reg) vclamp = pmax_reg;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;
    assign load_out = (state_reg == S_PUT) && (!ovalid_reg || m_tready);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            out_reg    <= '0;
        end
        else if (load_out)
        begin
            out_reg    <= {7'd0, (goal >= pmax_reg) ? {PW{1'b0}} : drsp.quo, cur,
                           cmode_reg, run_reg[1], run_reg[0], pwr_reg[1],
                           pwr_reg[0], dir_reg[1], dir_reg[0],
                           lvl_reg[1], lvl_reg[0]};
            ovalid_reg <= 1'b1;
        end
        else if (m_tready)
            ovalid_reg <= 1'b0;
    end

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= ACT_RAMP;
            m_reg      <= 1'b0;
            val_reg    <= '0;
            flag_reg   <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                half_reg[i] <= 24'd18750;
                goal_reg[i] <= 24'd18750;
                cnt_reg[i]  <= '0;
            end
            run_reg   <= '0;
            pwr_reg   <= '0;
            dir_reg   <= 2'b11;
            lvl_reg   <= 2'b11;
            egoal_reg <= '0;
            cmode_reg <= 1'b0;
            dreq      <= '0;
        end
        else
        begin
            dreq.start <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        act_reg   <= s_tdata[2:0];
                        m_reg     <= s_tdata[3];
                        val_reg   <= s_tdata[27:4];
                        flag_reg  <= s_tdata[28];
                        state_reg <= S_D1;
                        dreq.num  <= conv_reg;
                        if (s_tdata[2:0] == ACT_RAMP)
                        begin
                            dreq.den   <= half_reg[s_tdata[3]];
                            dreq.start <= 1'b1;
                        end
                        else if (s_tdata[2:0] == ACT_RPM)
                        begin
                            dreq.den   <= s_tdata[27:4];
                            dreq.start <= 1'b1;
                        end
                        else if (s_tdata[2:0] == ACT_RUN)
                        begin
                            dreq.den   <= PW'(drpm_reg);
                            dreq.start <= 1'b1;
                        end
                        else
                            state_reg <= S_FIN;
                    end
                S_D1:
                    if (drsp.done)
                    begin
                        case (act_reg)
                            ACT_RAMP:
                                if (cur == goal)
                                    state_reg <= S_FIN;
                                else
                                begin
                                    if (cur > goal)
                                        dreq.den <= (up_rpm > (PW+1)'(rmax_reg)) ?
                                            PW'(rmax_reg) : up_rpm[PW-1:0];
                                    else
                                        dreq.den <= (dn_neg || dn_rpm < (PW+1)'(rmin_reg)) ?
                                            PW'(rmin_reg) : dn_rpm[PW-1:0];
                                    dreq.start <= 1'b1;
                                    state_reg  <= S_D2;
                                end
                            ACT_RPM:
                            begin
                                cmode_reg <= 1'b0;
                                if (val_reg == '0)
                                begin
                                    goal_reg[m_reg] <= pmax_reg;
                                    run_reg[m_reg]  <= 1'b0;
                                end
                                else
                                begin
                                    goal_reg[m_reg] <= clamped;
                                    run_reg[m_reg]  <= 1'b1;
                                end
                                state_reg <= S_FIN;
                            end
                            default:
                            begin
                                egoal_reg   <= {val_reg, 3'b000} & {CW{1'b1}};
                                cnt_reg[0]  <= '0;
                                cnt_reg[1]  <= '0;
                                goal_reg[0] <= drsp.quo;
                                goal_reg[1] <= drsp.quo;
                                cmode_reg   <= 1'b1;
                                run_reg     <= 2'b11;
                                state_reg   <= S_FIN;
                            end
                        endcase
                    end
                S_D2:
                    if (drsp.done)
                    begin
                        half_reg[m_reg] <= np;
                        state_reg <= S_FIN;
                    end
                S_FIN:
                begin
                    case (act_reg)
                        ACT_RAMP:
                            if (cur >= pmax_reg)
                            begin
                                cmode_reg       <= 1'b0;
                                run_reg[m_reg]  <= 1'b0;
                                goal_reg[m_reg] <= pmax_reg;
                            end
                        ACT_STEP:
                            if (run_reg[m_reg])
                            begin
                                lvl_reg[m_reg] <= !lvl_reg[m_reg];
                                if (!lvl_reg[m_reg])
                                begin
                                    cnt_reg[m_reg] <= cnt_reg[m_reg] + 1'b1;
                                    if (cmode_reg && cnt_reg[m_reg] + 1'b1 == egoal_reg)
                                    begin
                                        run_reg   <= 2'b00;
                                        cmode_reg <= 1'b0;
                                    end
                                end
                            end
                        ACT_PERIOD: goal_reg[m_reg] <= vclamp;
                        ACT_ENABLE:
                        begin
                            cmode_reg      <= 1'b0;
                            run_reg[m_reg] <= flag_reg;
                            if (!flag_reg) goal_reg[m_reg] <= pmax_reg;
                        end
                        ACT_POWER:
                        begin
                            pwr_reg[m_reg] <= flag_reg;
                            if (!flag_reg) goal_reg[m_reg] <= pmax_reg;
                        end
                        ACT_DIR: dir_reg[m_reg] <= flag_reg;
                        default: ;
                    endcase
                    state_reg <= S_D3;
                end
                S_D3:
                begin
                    // goal now final: compute reported rpm
                    dreq.num   <= conv_reg;
                    dreq.den   <= goal;
                    dreq.start <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                    if (drsp.done)
                        state_reg <= S_PUT;
                S_PUT:
                    // quotient stays on the divider until the next request
                    if (load_out)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !m_tready |=> ovalid_reg) else $error("result dropped");
    a_cmode_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmode_reg |-> run_reg == 2'b11)
        else $error("mode");
endmodule

[design/dsrc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle; zero divisor saturates.
// Depends on dsrc_pkg.
`timescale 1ns / 1ps
module dsrc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dsrc_pkg::div_req_t req,
    output dsrc_pkg::div_rsp_t rsp
);
    import dsrc_pkg::*;

    logic [PW-1:0] quo_reg;
    logic [PW:0]   rem_reg;
    logic [PW-1:0] den_reg;
    logic [4:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [PW:0]   trial;
    logic [PW:0]   shifted;

    assign shifted = {rem_reg[PW-1:0], quo_reg[PW-1]};
    assign trial   = shifted - {1'b0, den_reg};

    // shift-subtract sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quo_reg <= req.num;
                rem_reg <= '0;
                den_reg <= req.den;
                cnt_reg <= 5'(PW);
                if (req.den == '0)
                begin
                    quo_reg  <= PMASK;
                    done_reg <= 1'b1;
                end
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!trial[PW])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[PW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(req.start)) else $error("done held");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg) else $error("done while busy");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 5'd0) else $error("count underflow");
endmodule

[test/tb.sv]
// Testbench for the dual stepper ramp controller: directed and random commands.
// Holds its own model of both motors and checks every response field by field.
// Depends on dsrc_pkg and dual_stepper_ramp_controller_top.
`timescale 1ns / 1ps
module tb;
    import dsrc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    dual_stepper_ramp_controller_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // register copies
    int unsigned ramp_rate_r, steps_rpm_r, conv_r, rpm_lo_r, rpm_hi_r, per_lo_r, per_hi_r;

    // motor state copies
    logic [23:0] half_per [2];
    logic [23:0] goal_per [2];
    logic        run_on   [2];
    logic        pwr_on   [2];
    logic        dir_on   [2];
    logic        step_lvl [2];
    int unsigned edge_cnt [2];
    int unsigned edge_tgt;
    logic        counted;

    logic [63:0] status_q [$];
    int          errors;
    int          rx_hold;
    bit          no_gaps;

    // field layout of the response, lowest bit up
    string       fld_name [11] = '{"step_level_a", "step_level_b", "direction_a", "direction_b",
                                   "powered_a", "powered_b", "running_a", "running_b",
                                   "counted_mode", "period_now", "rpm_now"};
    int          fld_lsb  [11] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 33};
    int          fld_wid  [11] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 24, 24};

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end

    // saturating divide
    function automatic logic [23:0] div_sat(input int unsigned n, input int unsigned d);
        if (d == 0)
            return 24'hFFFFFF;
        return 24'((n / d) & 32'hFFFFFF);
    endfunction

    function automatic logic [23:0] clamp_goal(input int unsigned p);
        if (p < per_lo_r)
            return per_lo_r[23:0];
        if (p > per_hi_r)
            return per_hi_r[23:0];
        return p[23:0];
    endfunction

    function automatic void stop_motor(input int m);
        counted = 1'b0;
        run_on[m] = 1'b0;
        goal_per[m] = per_hi_r[23:0];
    endfunction

    function automatic void reset_motors();
        for (int m = 0; m < 2; m++)
        begin
            half_per[m] = per_hi_r[23:0];
            goal_per[m] = per_hi_r[23:0];
            run_on[m]   = 1'b0;
            pwr_on[m]   = 1'b0;
            dir_on[m]   = 1'b1;
            step_lvl[m] = 1'b1;
            edge_cnt[m] = 0;
        end
        edge_tgt = 0;
        counted  = 1'b0;
    endfunction

    // one ramp step toward the goal period
    function automatic void ramp_motor(input int m);
        int unsigned cur;
        int unsigned goal;
        int unsigned rpm;
        int unsigned np;
        longint      nr;
        cur  = 32'(half_per[m]);
        goal = 32'(goal_per[m]);
        rpm  = 32'(div_sat(conv_r, cur));
        if (cur > goal)
        begin
            nr = longint'(rpm) + longint'(ramp_rate_r);
            if (nr > longint'(rpm_hi_r))
                nr = longint'(rpm_hi_r);
            np = 32'(div_sat(conv_r, 32'(nr)));
            if (np >= cur)
                np = cur - 1;
            if (np < goal)
                np = goal;
            half_per[m] = np[23:0];
        end
        else if (cur < goal)
        begin
            nr = longint'(rpm) - longint'(ramp_rate_r);
            if (nr < longint'(rpm_lo_r))
                nr = longint'(rpm_lo_r);
            np = 32'(div_sat(conv_r, 32'(nr)));
            if (np <= cur)
                np = cur + 1;
            if (np > goal)
                np = goal;
            half_per[m] = np[23:0];
        end
        if (half_per[m] >= per_hi_r)
            stop_motor(m);
    endfunction

    function automatic void step_motor(input int m);
        if (!run_on[m])
            return;
        if (step_lvl[m])
        begin
            step_lvl[m] = 1'b0;
            return;
        end
        step_lvl[m] = 1'b1;
        edge_cnt[m] = edge_cnt[m] + 1;
        if (counted && edge_cnt[m] == edge_tgt)
        begin
            run_on[0] = 1'b0;
            run_on[1] = 1'b0;
            counted   = 1'b0;
        end
    endfunction

    // apply one command and return the expected status word
    function automatic logic [63:0] apply_command(input logic [2:0] act, input int m,
                                                  input logic [23:0] val, input logic flg);
        logic [23:0] g;
        logic [23:0] rpm_rep;
        case (act)
            ACT_RAMP: ramp_motor(m);
            ACT_STEP: step_motor(m);
            ACT_RPM:
            begin
                counted = 1'b0;
                if (val == 0)
                begin
                    goal_per[m] = per_hi_r[23:0];
                    run_on[m] = 1'b0;
                end
                else
                begin
                    goal_per[m] = clamp_goal(32'(div_sat(conv_r, 32'(val))));
                    run_on[m] = 1'b1;
                end
            end
            ACT_PERIOD: goal_per[m] = clamp_goal(32'(val));
            ACT_ENABLE:
            begin
                counted = 1'b0;
                run_on[m] = flg;
                if (!flg)
                    goal_per[m] = per_hi_r[23:0];
            end
            ACT_POWER:
            begin
                pwr_on[m] = flg;
                if (!flg)
                    goal_per[m] = per_hi_r[23:0];
            end
            ACT_DIR: dir_on[m] = flg;
            default:
            begin
                edge_tgt = 32'(val) * 8;
                edge_cnt[0] = 0;
                edge_cnt[1] = 0;
                g = div_sat(conv_r, steps_rpm_r);
                goal_per[0] = g;
                goal_per[1] = g;
                counted = 1'b1;
                run_on[0] = 1'b1;
                run_on[1] = 1'b1;
            end
        endcase
        g = goal_per[m];
        rpm_rep = (g >= per_hi_r) ? 24'd0 : div_sat(conv_r, 32'(g));
        return {7'd0, rpm_rep, half_per[m], counted, run_on[1], run_on[0],
                pwr_on[1], pwr_on[0], dir_on[1], dir_on[0], step_lvl[1], step_lvl[0]};
    endfunction

    // send one command; the expectation is formed at acceptance
    task automatic send_cmd(input logic [2:0] act, input logic mtr, input logic [23:0] val,
                            input logic flg);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, flg, val, mtr, act};
        do
            @(posedge clk);
        while (!s_tready);
        status_q.push_back(apply_command(act, int'(mtr), val, flg));
    endtask

    // wait for every response, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // register write, block idle
    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RATE: ramp_rate_r = val & 32'h7F;
            REG_DRPM: steps_rpm_r = val & 32'h3FF;
            REG_CONV: conv_r      = val & 32'hFFFFFF;
            REG_RMIN: rpm_lo_r    = val & 32'h3FF;
            REG_RMAX: rpm_hi_r    = val & 32'h3FF;
            REG_PMIN: per_lo_r    = val & 32'hFFFFFF;
            default:  per_hi_r    = val & 32'hFFFFFF;
        endcase
    endtask

    task automatic load_config(input int unsigned rate, input int unsigned drpm,
                               input int unsigned conv, input int unsigned rlo,
                               input int unsigned rhi, input int unsigned plo,
                               input int unsigned phi);
        drain();
        write_reg(REG_RATE, rate);
        write_reg(REG_DRPM, drpm);
        write_reg(REG_CONV, conv);
        write_reg(REG_RMIN, rlo);
        write_reg(REG_RMAX, rhi);
        write_reg(REG_PMIN, plo);
        write_reg(REG_PMAX, phi);
    endtask

    // one random command, mostly meaningful motor traffic
    task automatic random_cmd();
        int          pick;
        logic [2:0]  act;
        logic [23:0] val;
        logic        flg;
        pick = $urandom_range(0, 99);
        val  = 24'($urandom);
        flg  = 1'($urandom);
        if (pick < 35)
            act = ACT_RAMP;
        else if (pick < 60)
            act = ACT_STEP;
        else if (pick < 70)
        begin
            act = ACT_RPM;
            if ($urandom_range(0, 9) < 8)
                val = 24'($urandom_range(0, 400));
        end
        else if (pick < 78)
        begin
            act = ACT_PERIOD;
            if ($urandom_range(0, 9) < 8)
                val = 24'($urandom_range(30, 20000));
        end
        else if (pick < 84)
        begin
            act = ACT_ENABLE;
            flg = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 89)
            act = ACT_POWER;
        else if (pick < 94)
            act = ACT_DIR;
        else
        begin
            act = ACT_RUN;
            if ($urandom_range(0, 9) < 8)
                val = 24'($urandom_range(0, 4));
        end
        send_cmd(act, 1'($urandom), val, flg);
    endtask

    // receiver: random stalls per response, plus long hold-offs on demand
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall = rx_hold;
                rx_hold = 0;
            end
            else
                stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // response checker
    always @(posedge clk)
    begin
        logic [63:0] exp_w;
        logic [31:0] e;
        logic [31:0] a;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
            begin
                $error("response with no command pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                exp_w = status_q.pop_front();
                for (int f = 0; f < 11; f++)
                begin
                    e = 32'((exp_w >> fld_lsb[f]) & ((64'd1 << fld_wid[f]) - 1));
                    a = 32'((m_tdata >> fld_lsb[f]) & ((64'd1 << fld_wid[f]) - 1));
                    if (e !== a)
                    begin
                        $error("%s: expected %0d, got %0d", fld_name[f], e, a);
                        errors++;
                    end
                end
            end
        end
    end

    // extremes of every field and each special case, reset configuration
    task automatic test_directed();
        send_cmd(ACT_STEP, 1'b0, 24'd0, 1'b0);          // stopped motor: no change
        send_cmd(ACT_RAMP, 1'b1, 24'hFFFFFF, 1'b1);     // already at goal
        send_cmd(ACT_DIR, 1'b0, 24'd0, 1'b0);
        send_cmd(ACT_DIR, 1'b1, 24'hFFFFFF, 1'b1);
        send_cmd(ACT_POWER, 1'b0, 24'd0, 1'b1);
        send_cmd(ACT_POWER, 1'b1, 24'd5, 1'b1);
        send_cmd(ACT_RPM, 1'b0, 24'd120, 1'b0);
        repeat (4) send_cmd(ACT_RAMP, 1'b0, 24'd0, 1'b0);
        repeat (3) send_cmd(ACT_STEP, 1'b0, 24'd0, 1'b0);
        send_cmd(ACT_RPM, 1'b1, 24'hFFFFFF, 1'b0);      // clamps to period_min
        send_cmd(ACT_PERIOD, 1'b1, 24'd0, 1'b0);
        send_cmd(ACT_PERIOD, 1'b0, 24'hFFFFFF, 1'b0);   // clamps to period_max
        send_cmd(ACT_RAMP, 1'b0, 24'd0, 1'b0);          // one ramp step toward period_max
        send_cmd(ACT_RPM, 1'b0, 24'd0, 1'b1);           // rpm zero stops
        send_cmd(ACT_ENABLE, 1'b1, 24'd0, 1'b0);
        send_cmd(ACT_ENABLE, 1'b1, 24'd0, 1'b1);
        send_cmd(ACT_RUN, 1'b1, 24'd1, 1'b0);           // counted run; both motors stop at the edge goal
        repeat (4) send_cmd(ACT_RAMP, 1'b0, 24'd0, 1'b0);
        send_cmd(ACT_RUN, 1'b0, 24'd0, 1'b1);           // goal zero, needs a wrap
        send_cmd(ACT_RUN, 1'b0, 24'hFFFFFF, 1'b1);
        send_cmd(ACT_POWER, 1'b0, 24'd0, 1'b0);         // power off drops goal
    endtask

    // register extremes, including divide by zero and inverted clamps
    task automatic test_config_extremes();
        load_config(0, 0, 1, 0, 0, 0, 16777215);        // zero rpm limits, steps rpm and period_min
        send_cmd(ACT_PERIOD, 1'b0, 24'd0, 1'b0);
        send_cmd(ACT_RPM, 1'b0, 24'd3, 1'b0);
        send_cmd(ACT_RAMP, 1'b0, 24'd0, 1'b0);
        send_cmd(ACT_RUN, 1'b1, 24'd2, 1'b0);
        repeat (3) send_cmd(ACT_RAMP, 1'b1, 24'd0, 1'b0);
        load_config(127, 1023, 16777215, 1023, 1023, 16777215, 1); // inverted clamps
        send_cmd(ACT_RPM, 1'b1, 24'd50, 1'b0);
        send_cmd(ACT_PERIOD, 1'b0, 24'd100, 1'b0);
        repeat (3) send_cmd(ACT_RAMP, 1'b0, 24'd0, 1'b0);
        send_cmd(ACT_RUN, 1'b0, 24'd3, 1'b0);
        repeat (3) send_cmd(ACT_RAMP, 1'b1, 24'd0, 1'b0);
        load_config(100, 1, 1000000, 1, 1000, 1, 200000);
        send_cmd(ACT_RPM, 1'b0, 24'd900, 1'b0);
        repeat (6) send_cmd(ACT_RAMP, 1'b0, 24'd0, 1'b0);
        send_cmd(ACT_RPM, 1'b0, 24'd5, 1'b0);
        repeat (6) send_cmd(ACT_RAMP, 1'b0, 24'd0, 1'b0);
    endtask

    // random phases, each under a fresh register setting
    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            if ($urandom_range(0, 2) == 0)
                load_config(10, 60, 18750, 1, 300, 60, 18750);
            else
                load_config($urandom_range(0, 100), $urandom_range(1, 1000),
                            $urandom_range(1000, 200000), $urandom_range(1, 50),
                            $urandom_range(100, 1000), $urandom_range(1, 100),
                            $urandom_range(5000, 60000));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (per_phase) random_cmd();
            no_gaps = 1'b0;
        end
    endtask

    // receiver holds off while commands keep coming
    task automatic test_backpressure();
        rx_hold = 400;
        repeat (20) random_cmd();
    endtask

    // sender pauses until the block has answered everything
    task automatic test_pause();
        repeat (10) random_cmd();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (10) random_cmd();
    endtask

    initial
    begin
        errors   = 0;
        rx_hold  = 0;
        no_gaps  = 1'b0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        ramp_rate_r = 10;
        steps_rpm_r = 60;
        conv_r      = 18750;
        rpm_lo_r    = 1;
        rpm_hi_r    = 300;
        per_lo_r    = 60;
        per_hi_r    = 18750;
        reset_motors();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random(10, 64);
        test_pause();
        test_backpressure();

        drain();
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
